FILE: hw/rtl/sbf_pkg.sv
// Shared constants and types for the spring / bungee force pipeline.
package sbf_pkg;

   localparam int FRACTION_BITS_DEF = 16;

   localparam int COORD_W    = 32;            // position and force words
   localparam int CSR_DATA_W = 32;            // widest register
   localparam int CSR_INDEX_W = 2;
   localparam int ABS_W      = COORD_W + 1;   // |P - E| up to 2^32 - 1
   localparam int SQ_W       = 2 * ABS_W;     // one squared component
   localparam int SUM_W      = SQ_W + 2;      // sum of three squares
   localparam int ROOT_W     = SUM_W / 2;     // floor sqrt of the sum
   localparam int SQRT_REM_W = ROOT_W + 3;
   localparam int EXT_W      = ROOT_W + 1;    // signed L - r
   localparam int HALF_W     = ROOT_W / 2;    // split of |X| for the k multiply
   localparam int PROD_W     = CSR_DATA_W + ROOT_W;
   localparam int DREM_W     = ROOT_W + 1;    // divider remainder

   localparam logic [CSR_DATA_W-1:0] SPRING_CONSTANT_RESET = 32'h0001_0000;
   localparam logic [CSR_DATA_W-1:0] REST_LENGTH_RESET     = 32'h0000_0000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SPRING_CONSTANT = 2'd0,
      CSR_REST_LENGTH     = 2'd1,
      CSR_MODE            = 2'd2
   } csr_index_type;

   // Per-request status carried down the back half of the pipe.
   typedef struct packed {
      logic zero;      // zero separation
      logic slack;     // bungee not stretched
      logic ext_neg;   // spring compressed
   } force_flags_type;

endpackage

FILE: hw/rtl/spring_bungee_force_unit.sv
// Spring / bungee force unit: fully pipelined 3D Hooke force in fixed point.
// Each request comes out, in order, as one rsp_valid strobe; at the default FRACTION_BITS the words are Q16.16.
// Throughput: one request per cycle; busy is always low, the pipe never stalls.
// The depth is set by the square root (one root bit per stage, 34 stages) and the
// three unit-vector dividers (one quotient bit per stage, FRACTION_BITS+1 stages).
// Reset clears the valid bits of every stage and loads k = 1.0, r = 0, spring mode.
module spring_bungee_force_unit #(
   parameter int FRACTION_BITS = sbf_pkg::FRACTION_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic signed [sbf_pkg::COORD_W-1:0]     req_pos_x,
   input  logic signed [sbf_pkg::COORD_W-1:0]     req_pos_y,
   input  logic signed [sbf_pkg::COORD_W-1:0]     req_pos_z,
   input  logic signed [sbf_pkg::COORD_W-1:0]     req_end_x,
   input  logic signed [sbf_pkg::COORD_W-1:0]     req_end_y,
   input  logic signed [sbf_pkg::COORD_W-1:0]     req_end_z,
   input  logic                                   csr_we,
   input  logic [sbf_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [sbf_pkg::CSR_DATA_W-1:0]         csr_wdata,
   output logic                                   rsp_valid,
   output logic signed [sbf_pkg::COORD_W-1:0]     rsp_force_x,
   output logic signed [sbf_pkg::COORD_W-1:0]     rsp_force_y,
   output logic signed [sbf_pkg::COORD_W-1:0]     rsp_force_z,
   output logic                                   rsp_applied,
   output logic                                   rsp_saturated
);
   import sbf_pkg::*;

   localparam int MAG_W   = PROD_W - FRACTION_BITS;   // k*|X| >> F
   localparam int QUO_W   = FRACTION_BITS + 1;        // unit component, up to 1.0
   localparam int UPROD_W = MAG_W + QUO_W;
   localparam int P_W     = UPROD_W - FRACTION_BITS;
   localparam int LATENCY = 3 + ROOT_W + 3 + QUO_W + 2;

   localparam logic [P_W-1:0] POS_LIM = P_W'(64'h0000_0000_7FFF_FFFF);
   localparam logic [P_W-1:0] NEG_LIM = P_W'(64'h0000_0000_8000_0000);

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [CSR_DATA_W-1:0] k_ff;
   logic [CSR_DATA_W-1:0] rest_ff;
   logic                  mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff    <= SPRING_CONSTANT_RESET;
         rest_ff <= REST_LENGTH_RESET;
         mode_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_SPRING_CONSTANT: k_ff    <= csr_wdata;
            CSR_REST_LENGTH:     rest_ff <= csr_wdata;
            CSR_MODE:            mode_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Every request is taken; nothing downstream can push back.
   assign busy = 1'b0;

   // ------------------------------------------------------------------
   // Stage A: separation D = P - E, kept as magnitude and sign per axis
   // ------------------------------------------------------------------
   logic signed [COORD_W-1:0] pos_w [3];
   logic signed [COORD_W-1:0] end_w [3];
   logic [ABS_W-1:0]          a_abs_in [3];
   logic                      a_neg_in [3];
   logic [ABS_W-1:0]          diff_w [3];

   assign pos_w[0] = req_pos_x;
   assign pos_w[1] = req_pos_y;
   assign pos_w[2] = req_pos_z;
   assign end_w[0] = req_end_x;
   assign end_w[1] = req_end_y;
   assign end_w[2] = req_end_z;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         diff_w[i]   = {pos_w[i][COORD_W-1], pos_w[i]} - {end_w[i][COORD_W-1], end_w[i]};
         a_neg_in[i] = diff_w[i][ABS_W-1];
         a_abs_in[i] = a_neg_in[i] ? (~diff_w[i] + ABS_W'(1)) : diff_w[i];
      end
   end

   logic             a_valid_ff;
   logic [ABS_W-1:0] a_abs_ff [3];
   logic             a_neg_ff [3];

   always_ff @(posedge clock) begin
      if (reset) a_valid_ff <= 1'b0;
      else       a_valid_ff <= start & ~busy;
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         a_abs_ff[i] <= a_abs_in[i];
         a_neg_ff[i] <= a_neg_in[i];
      end
   end

   // ------------------------------------------------------------------
   // Stage B: squares
   // ------------------------------------------------------------------
   logic             b_valid_ff;
   logic [SQ_W-1:0]  b_sq_ff  [3];
   logic [ABS_W-1:0] b_abs_ff [3];
   logic             b_neg_ff [3];

   always_ff @(posedge clock) begin
      if (reset) b_valid_ff <= 1'b0;
      else       b_valid_ff <= a_valid_ff;
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         b_sq_ff[i]  <= SQ_W'(a_abs_ff[i]) * SQ_W'(a_abs_ff[i]);
         b_abs_ff[i] <= a_abs_ff[i];
         b_neg_ff[i] <= a_neg_ff[i];
      end
   end

   // ------------------------------------------------------------------
   // Stage C + square root: index 0 holds the sum, each later index one
   // more root bit (restoring digit-by-digit, two radicand bits a stage).
   // ------------------------------------------------------------------
   logic                  s_valid_ff [0:ROOT_W];
   logic [SUM_W-1:0]      s_op_ff    [0:ROOT_W];
   logic [SQRT_REM_W-1:0] s_rem_ff   [0:ROOT_W];
   logic [ROOT_W-1:0]     s_root_ff  [0:ROOT_W];
   logic [ABS_W-1:0]      s_abs_ff   [0:ROOT_W][3];
   logic                  s_neg_ff   [0:ROOT_W][3];

   always_ff @(posedge clock) begin
      if (reset) s_valid_ff[0] <= 1'b0;
      else       s_valid_ff[0] <= b_valid_ff;
   end

   always_ff @(posedge clock) begin
      s_op_ff[0]   <= SUM_W'(b_sq_ff[0]) + SUM_W'(b_sq_ff[1]) + SUM_W'(b_sq_ff[2]);
      s_rem_ff[0]  <= '0;
      s_root_ff[0] <= '0;
      for (int i = 0; i < 3; i++) begin
         s_abs_ff[0][i] <= b_abs_ff[i];
         s_neg_ff[0][i] <= b_neg_ff[i];
      end
   end

   for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
      logic [SQRT_REM_W-1:0] rem_sh;
      logic [SQRT_REM_W-1:0] trial;
      logic                  ge;

      assign rem_sh = {s_rem_ff[g][SQRT_REM_W-3:0], s_op_ff[g][SUM_W-1 -: 2]};
      assign trial  = {1'b0, s_root_ff[g], 2'b01};
      assign ge     = (rem_sh >= trial);

      always_ff @(posedge clock) begin
         if (reset) s_valid_ff[g+1] <= 1'b0;
         else       s_valid_ff[g+1] <= s_valid_ff[g];
      end

      always_ff @(posedge clock) begin
         s_rem_ff[g+1]  <= ge ? (rem_sh - trial) : rem_sh;
         s_root_ff[g+1] <= {s_root_ff[g][ROOT_W-2:0], ge};
         s_op_ff[g+1]   <= s_op_ff[g] << 2;
         for (int i = 0; i < 3; i++) begin
            s_abs_ff[g+1][i] <= s_abs_ff[g][i];
            s_neg_ff[g+1][i] <= s_neg_ff[g][i];
         end
      end
   end

   // ------------------------------------------------------------------
   // Stage E: extension X = L - r, special cases
   // ------------------------------------------------------------------
   logic [ROOT_W-1:0] len_w;
   logic [EXT_W-1:0]  ext_w;
   force_flags_type   e_flags_in;
   logic [ROOT_W-1:0] e_ext_abs_in;

   assign len_w = s_root_ff[ROOT_W];
   assign ext_w = {1'b0, len_w} - EXT_W'(rest_ff);

   always_comb begin
      e_flags_in.zero    = (len_w == '0);
      e_flags_in.ext_neg = ext_w[EXT_W-1];
      e_flags_in.slack   = mode_ff & (ext_w[EXT_W-1] | (ext_w == '0));
      e_ext_abs_in       = ext_w[EXT_W-1] ? ROOT_W'(~ext_w + EXT_W'(1)) : ROOT_W'(ext_w);
   end

   logic              e_valid_ff;
   force_flags_type   e_flags_ff;
   logic [ROOT_W-1:0] e_ext_abs_ff;
   logic [ROOT_W-1:0] e_len_ff;
   logic [ABS_W-1:0]  e_abs_ff [3];
   logic              e_neg_ff [3];

   always_ff @(posedge clock) begin
      if (reset) e_valid_ff <= 1'b0;
      else       e_valid_ff <= s_valid_ff[ROOT_W];
   end

   always_ff @(posedge clock) begin
      e_flags_ff   <= e_flags_in;
      e_ext_abs_ff <= e_ext_abs_in;
      e_len_ff     <= len_w;
      for (int i = 0; i < 3; i++) begin
         e_abs_ff[i] <= s_abs_ff[ROOT_W][i];
         e_neg_ff[i] <= s_neg_ff[ROOT_W][i];
      end
   end

   // ------------------------------------------------------------------
   // Stages M1/M2: M = k*|X| >> F, as two half-width partial products
   // ------------------------------------------------------------------
   logic                               m1_valid_ff;
   logic [CSR_DATA_W+HALF_W-1:0]       m1_lo_ff;
   logic [CSR_DATA_W+HALF_W-1:0]       m1_hi_ff;
   force_flags_type                    m1_flags_ff;
   logic [ROOT_W-1:0]                  m1_len_ff;
   logic [ABS_W-1:0]                   m1_abs_ff [3];
   logic                               m1_neg_ff [3];

   always_ff @(posedge clock) begin
      if (reset) m1_valid_ff <= 1'b0;
      else       m1_valid_ff <= e_valid_ff;
   end

   always_ff @(posedge clock) begin
      m1_lo_ff    <= (CSR_DATA_W+HALF_W)'(k_ff) * (CSR_DATA_W+HALF_W)'(e_ext_abs_ff[HALF_W-1:0]);
      m1_hi_ff    <= (CSR_DATA_W+HALF_W)'(k_ff) * (CSR_DATA_W+HALF_W)'(e_ext_abs_ff[ROOT_W-1:HALF_W]);
      m1_flags_ff <= e_flags_ff;
      m1_len_ff   <= e_len_ff;
      for (int i = 0; i < 3; i++) begin
         m1_abs_ff[i] <= e_abs_ff[i];
         m1_neg_ff[i] <= e_neg_ff[i];
      end
   end

   logic [PROD_W-1:0] kx_full;
   assign kx_full = PROD_W'(m1_lo_ff) + (PROD_W'(m1_hi_ff) << HALF_W);

   // ------------------------------------------------------------------
   // Unit vector dividers: Q = |D| * 2^F / L, one quotient bit a stage.
   // Index 0 is the M2 register; |D| <= L so Q fits F+1 bits.
   // ------------------------------------------------------------------
   logic              d_valid_ff [0:QUO_W];
   logic [MAG_W-1:0]  d_mag_ff   [0:QUO_W];
   force_flags_type   d_flags_ff [0:QUO_W];
   logic [ROOT_W-1:0] d_len_ff   [0:QUO_W];
   logic [DREM_W-1:0] d_rem_ff   [0:QUO_W][3];
   logic [QUO_W-1:0]  d_quo_ff   [0:QUO_W][3];
   logic              d_neg_ff   [0:QUO_W][3];

   always_ff @(posedge clock) begin
      if (reset) d_valid_ff[0] <= 1'b0;
      else       d_valid_ff[0] <= m1_valid_ff;
   end

   always_ff @(posedge clock) begin
      d_mag_ff[0]   <= kx_full[PROD_W-1:FRACTION_BITS];
      d_flags_ff[0] <= m1_flags_ff;
      d_len_ff[0]   <= m1_len_ff;
      for (int i = 0; i < 3; i++) begin
         d_rem_ff[0][i] <= DREM_W'(m1_abs_ff[i]);
         d_quo_ff[0][i] <= '0;
         d_neg_ff[0][i] <= m1_neg_ff[i];
      end
   end

   for (genvar g = 0; g < QUO_W; g++) begin : g_div
      logic [DREM_W-1:0] trial [3];
      logic              ge    [3];

      always_comb begin
         for (int i = 0; i < 3; i++) begin
            // first step weighs the integer bit; later steps bring in a zero
            trial[i] = (g == 0) ? d_rem_ff[g][i] : (d_rem_ff[g][i] << 1);
            ge[i]    = (trial[i] >= DREM_W'(d_len_ff[g]));
         end
      end

      always_ff @(posedge clock) begin
         if (reset) d_valid_ff[g+1] <= 1'b0;
         else       d_valid_ff[g+1] <= d_valid_ff[g];
      end

      always_ff @(posedge clock) begin
         d_mag_ff[g+1]   <= d_mag_ff[g];
         d_flags_ff[g+1] <= d_flags_ff[g];
         d_len_ff[g+1]   <= d_len_ff[g];
         for (int i = 0; i < 3; i++) begin
            d_rem_ff[g+1][i] <= ge[i] ? (trial[i] - DREM_W'(d_len_ff[g])) : trial[i];
            d_quo_ff[g+1][i] <= {d_quo_ff[g][i][QUO_W-2:0], ge[i]};
            d_neg_ff[g+1][i] <= d_neg_ff[g][i];
         end
      end
   end

   // ------------------------------------------------------------------
   // Stage P: M * Q per axis
   // ------------------------------------------------------------------
   logic               p_valid_ff;
   logic [UPROD_W-1:0] p_prod_ff [3];
   logic               p_neg_ff  [3];
   force_flags_type    p_flags_ff;

   always_ff @(posedge clock) begin
      if (reset) p_valid_ff <= 1'b0;
      else       p_valid_ff <= d_valid_ff[QUO_W];
   end

   always_ff @(posedge clock) begin
      p_flags_ff <= d_flags_ff[QUO_W];
      for (int i = 0; i < 3; i++) begin
         p_prod_ff[i] <= UPROD_W'(d_mag_ff[QUO_W]) * UPROD_W'(d_quo_ff[QUO_W][i]);
         p_neg_ff[i]  <= d_neg_ff[QUO_W][i];
      end
   end

   // ------------------------------------------------------------------
   // Stage O: sign, saturation, special cases, result register
   // ------------------------------------------------------------------
   logic [P_W-1:0]     o_mag    [3];
   logic               o_resneg [3];
   logic               o_over   [3];
   logic [COORD_W-1:0] o_val    [3];
   logic [COORD_W-1:0] force_in [3];
   logic               applied_in;
   logic               saturated_in;

   always_comb begin
      applied_in   = ~(p_flags_ff.zero | p_flags_ff.slack);
      saturated_in = 1'b0;
      for (int i = 0; i < 3; i++) begin
         o_mag[i]    = p_prod_ff[i][UPROD_W-1:FRACTION_BITS];
         // force opposes extension along D
         o_resneg[i] = ~(p_flags_ff.ext_neg ^ p_neg_ff[i]);
         o_over[i]   = o_resneg[i] ? (o_mag[i] > NEG_LIM) : (o_mag[i] > POS_LIM);
         if (o_resneg[i])
            o_val[i] = o_over[i] ? NEG_LIM[COORD_W-1:0] : (~o_mag[i][COORD_W-1:0] + COORD_W'(1));
         else
            o_val[i] = o_over[i] ? POS_LIM[COORD_W-1:0] : o_mag[i][COORD_W-1:0];
         force_in[i]  = applied_in ? o_val[i] : '0;
         saturated_in = saturated_in | (applied_in & o_over[i]);
      end
   end

   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= p_valid_ff;
   end

   always_ff @(posedge clock) begin
      rsp_force_x   <= force_in[0];
      rsp_force_y   <= force_in[1];
      rsp_force_z   <= force_in[2];
      rsp_applied   <= applied_in;
      rsp_saturated <= saturated_in;
   end

   assign rsp_valid = rsp_valid_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_fixed_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("request did not come out after the pipeline latency");

   a_idle_no_strobe: assert property (@(posedge clock) disable iff (reset)
      (!a_valid_ff && !b_valid_ff && !s_valid_ff[0]) |=> !s_valid_ff[1])
      else $error("sqrt stage valid appeared from nothing");

   a_not_applied_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_applied) |->
         (rsp_force_x == '0 && rsp_force_y == '0 && rsp_force_z == '0 && !rsp_saturated))
      else $error("force or saturation reported without an applied force");

   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_saturated) |->
         (rsp_force_x == 32'sh7FFF_FFFF || rsp_force_x == 32'sh8000_0000 ||
          rsp_force_y == 32'sh7FFF_FFFF || rsp_force_y == 32'sh8000_0000 ||
          rsp_force_z == 32'sh7FFF_FFFF || rsp_force_z == 32'sh8000_0000))
      else $error("saturation flagged but no component at a limit");

endmodule

FILE: bench/tb.sv
// Self-checking bench for the spring / bungee force unit.
module tb;
   import sbf_pkg::*;

   localparam int FB        = FRACTION_BITS_DEF;
   localparam int WATCHDOG  = 5000;  // idle cycles before the run is declared hung
   localparam int SETTLE    = 80;    // longer than the pipe latency
   localparam int RAND_PER_PHASE = 195;
   // index 3 decodes to no register; used to check that such writes are dropped
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED = 2'd3;

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct {
      coord_type px, py, pz, ex, ey, ez;
   } spring_req_type;

   typedef struct {
      coord_type fx, fy, fz;
      logic      applied;
      logic      saturated;
   } force_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   coord_type req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   coord_type req_end_x = '0, req_end_y = '0, req_end_z = '0;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   logic      rsp_valid, rsp_applied, rsp_saturated;
   coord_type rsp_force_x, rsp_force_y, rsp_force_z;

   spring_bungee_force_unit u_dut (.*);

   // bench copy of the register file
   logic [31:0] k_model    = SPRING_CONSTANT_RESET;
   logic [31:0] rest_model = REST_LENGTH_RESET;
   logic        bungee_model = 1'b0;

   spring_req_type req_pending_q[$];
   force_rsp_type  force_exp_q[$];
   int             mismatches = 0;
   int             idle_cycles = 0;

   initial forever #5 clock = ~clock;

   // Hooke force, bit exact: floor sqrt length, truncating unit vector,
   // sign applied last so rounding goes toward zero, per-axis clamp.
   function automatic force_rsp_type spring_force_calc(spring_req_type r);
      force_rsp_type    f;
      logic signed [33:0] d[3];
      logic [32:0]      mag_d[3];
      logic             neg[3];
      logic [67:0]      sum_sq;
      logic [33:0]      len, cand;
      logic signed [35:0] ext;
      logic [34:0]      ext_abs;
      logic             ext_neg, res_neg;
      logic [127:0]     mag, unit, prod;
      logic [31:0]      v[3];
      f = '{fx: '0, fy: '0, fz: '0, applied: 1'b0, saturated: 1'b0};
      d[0] = 34'(r.px) - 34'(r.ex);
      d[1] = 34'(r.py) - 34'(r.ey);
      d[2] = 34'(r.pz) - 34'(r.ez);
      sum_sq = '0;
      for (int i = 0; i < 3; i++) begin
         neg[i]   = d[i] < 0;
         mag_d[i] = neg[i] ? 33'(-d[i]) : 33'(d[i]);
         sum_sq   = sum_sq + 68'(mag_d[i]) * 68'(mag_d[i]);
      end
      len = '0;
      for (int b = 33; b >= 0; b--) begin
         cand = len | (34'd1 << b);
         if (68'(cand) * 68'(cand) <= sum_sq) len = cand;
      end
      if (len == 0) return f;                       // zero separation
      ext = 36'(len) - 36'(rest_model);
      if (bungee_model && ext <= 0) return f;       // slack bungee
      f.applied = 1'b1;
      ext_neg = ext < 0;
      ext_abs = ext_neg ? 35'(-ext) : 35'(ext);
      mag = (128'(k_model) * 128'(ext_abs)) >> FB;
      for (int i = 0; i < 3; i++) begin
         unit    = (128'(mag_d[i]) << FB) / 128'(len);
         prod    = (mag * unit) >> FB;
         res_neg = !(ext_neg ^ neg[i]);
         if (res_neg) begin
            if (prod > 128'h8000_0000) begin
               prod = 128'h8000_0000;
               f.saturated = 1'b1;
            end
            v[i] = 32'(-prod);
         end else begin
            if (prod > 128'h7FFF_FFFF) begin
               prod = 128'h7FFF_FFFF;
               f.saturated = 1'b1;
            end
            v[i] = prod[31:0];
         end
      end
      f.fx = v[0];
      f.fy = v[1];
      f.fz = v[2];
      return f;
   endfunction

   // Driver: bursts of random length separated by random gaps.
   int burst_left = 1, gap_left = 0;
   always @(posedge clock) begin
      spring_req_type cur;
      spring_req_type acc;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            acc = '{req_pos_x, req_pos_y, req_pos_z, req_end_x, req_end_y, req_end_z};
            force_exp_q.insert(force_exp_q.size(), spring_force_calc(acc));
         end
         if (!start || !busy) begin
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (req_pending_q.size() > 0) begin
               cur = req_pending_q.pop_front();
               req_pos_x <= cur.px; req_pos_y <= cur.py; req_pos_z <= cur.pz;
               req_end_x <= cur.ex; req_end_y <= cur.ey; req_end_z <= cur.ez;
               start <= 1'b1;
               if (--burst_left == 0) begin
                  burst_left = $urandom_range(1, 40);
                  // a third of the bursts run straight into the next one
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
               end
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: every strobe must match the oldest prediction.
   always @(posedge clock) begin
      force_rsp_type want;
      if (!reset && rsp_valid) begin
         if (force_exp_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("tb: unexpected request result fx=%h", rsp_force_x);
         end else begin
            want = force_exp_q.pop_front();
            if (rsp_force_x !== want.fx || rsp_force_y !== want.fy ||
                rsp_force_z !== want.fz || rsp_applied !== want.applied ||
                rsp_saturated !== want.saturated) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("tb: mismatch exp %h %h %h a%b s%b got %h %h %h a%b s%b",
                           want.fx, want.fy, want.fz, want.applied, want.saturated,
                           rsp_force_x, rsp_force_y, rsp_force_z, rsp_applied,
                           rsp_saturated);
            end
         end
      end
   end

   // Watchdog on forward progress.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   task automatic add_req(coord_type px, coord_type py, coord_type pz,
                          coord_type ex, coord_type ey, coord_type ez);
      spring_req_type r;
      r = '{px, py, pz, ex, ey, ez};
      req_pending_q.insert(req_pending_q.size(), r);
   endtask

   task automatic csr_write(logic [CSR_INDEX_W-1:0] idx, logic [31:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_SPRING_CONSTANT: k_model = data;
         CSR_REST_LENGTH:     rest_model = data;
         CSR_MODE:            bungee_model = data[0];
         default: ;
      endcase
   endtask

   task automatic csr_done();
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Wait for the pipe to empty; the sender pauses here until all results are in.
   task automatic drain();
      while (req_pending_q.size() > 0 || start || force_exp_q.size() > 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Random request: mostly springs of random scale, some tiny, zero, at the rest length or full range.
   task automatic add_random();
      coord_type px, py, pz, dx, dy, dz;
      int sel;
      px = $urandom; py = $urandom; pz = $urandom;
      sel = $urandom_range(0, 9);
      case (sel)
         0, 1: begin dx = $urandom; dy = $urandom; dz = $urandom; end
         2: begin dx = 0; dy = 0; dz = 0; end
         3: begin           // axis-aligned at exactly the rest length
            dx = 0; dy = 0; dz = 0;
            case ($urandom_range(0, 2))
               0: dx = rest_model;
               1: dy = rest_model;
               default: dz = rest_model;
            endcase
            if ($urandom_range(0, 1)) begin dx = -dx; dy = -dy; dz = -dz; end
         end
         4, 5: begin
            dx = $signed($urandom_range(0, 32'h7)) - 3;
            dy = $signed($urandom_range(0, 32'h7)) - 3;
            dz = $signed($urandom_range(0, 32'h7)) - 3;
         end
         default: begin     // random magnitudes over many scales
            dx = $signed($urandom) >>> $urandom_range(0, 31);
            dy = $signed($urandom) >>> $urandom_range(0, 31);
            dz = $signed($urandom) >>> $urandom_range(0, 31);
         end
      endcase
      add_req(px, py, pz, px - dx, py - dy, pz - dz);
   endtask

   initial begin
      logic [31:0] k_set[8], r_set[8];
      logic        m_set[8];
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed set under reset values: k = 1.0, r = 0, spring mode
      add_req(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
              32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
      add_req(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
              32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      add_req(32'sh1234_5678, -5, 0, 32'sh1234_5678, -5, 0);   // zero separation
      add_req(0, 0, 0, 0, 0, 0);
      add_req(1, 0, 0, 0, 0, 0);                               // smallest length
      add_req(0, -1, 0, 0, 0, 0);
      add_req(32'sh0003_0000, 32'sh0004_0000, 0, 0, 0, 0);
      add_req(-32'sh0001_0000, 32'sh0002_0000, -32'sh0002_0000, 0, 0, 0);
      add_req(32'sh7FFF_FFFF, 0, 0, 32'sh8000_0000, 0, 0);
      drain();

      // rest length 3.0, bungee: slack, exactly at rest, stretched, zero separation
      csr_write(CSR_REST_LENGTH, 32'h0003_0000);
      csr_write(CSR_MODE, 32'hFFFF_FFFF);           // high bits must be dropped
      csr_write(CSR_UNMAPPED, 32'hDEAD_BEEF);       // no register behind it
      csr_done();
      add_req(32'sh0001_0000, 0, 0, 0, 0, 0);
      add_req(0, 32'sh0003_0000, 0, 0, 0, 0);
      add_req(0, 0, 32'sh0005_0000, 0, 0, 0);
      add_req(0, 0, 0, 0, 0, 0);
      drain();

      // spring mode: compressed, at rest, stretched; then huge k for clamping
      csr_write(CSR_MODE, 32'h0000_0000);
      csr_done();
      add_req(32'sh0001_0000, 0, 0, 0, 0, 0);
      add_req(0, 0, -32'sh0003_0000, 0, 0, 0);
      add_req(32'sh0005_0000, 0, 0, 0, 0, 0);
      drain();
      csr_write(CSR_SPRING_CONSTANT, 32'hFFFF_FFFF);
      csr_write(CSR_REST_LENGTH, 32'h0000_0000);
      csr_done();
      add_req(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 32'sh8000_0000, 32'sh8000_0000, 0);
      add_req(32'sh8000_0000, 0, 32'sh0100_0000, 32'sh7FFF_FFFF, 0, 0);
      add_req(32'sh0000_0100, 0, 0, 0, 0, 0);
      drain();

      // random phases over a spread of settings, extremes included
      k_set = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0001_0000, 32'h0000_0001,
                32'h0040_0000, 32'h0000_8000, 32'hFFFF_FFFF, 32'h0002_8000};
      r_set = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0010_0000, 32'h0000_0000,
                32'hFFFF_FFFF, 32'h0001_0000, 32'h0000_0004, 32'h8000_0000};
      m_set = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};
      for (int ph = 0; ph < 8; ph++) begin
         csr_write(CSR_SPRING_CONSTANT, (ph == 5) ? $urandom : k_set[ph]);
         csr_write(CSR_REST_LENGTH, (ph == 2) ? ($urandom >> 8) : r_set[ph]);
         csr_write(CSR_MODE, {31'($urandom), m_set[ph]});
         csr_done();
         for (int n = 0; n < RAND_PER_PHASE; n++) add_random();
         drain();
      end

      if (mismatches == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/sbf_pkg.sv
hw/rtl/spring_bungee_force_unit.sv
bench/tb.sv
